### hdl/axts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package axts_pkg;

  localparam int AES_ROUNDS = 10;
  localparam int RK_IDX_W   = $clog2(AES_ROUNDS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam logic [4:0] BLK_BYTES = 5'd16;
  localparam logic [7:0] ALPHA_POLY = 8'h87;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_KEY_LOW   = 3'd0,
    REG_DATA_KEY_HIGH  = 3'd1,
    REG_TWEAK_KEY_LOW  = 3'd2,
    REG_TWEAK_KEY_HIGH = 3'd3,
    REG_DECRYPT_MODE   = 3'd4
  } axts_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TWK_GO,
    ST_TWK_RUN,
    ST_HELD_GO,
    ST_HELD_RUN,
    ST_HELD_EMIT,
    ST_CUR_GO,
    ST_CUR_RUN,
    ST_CUR_EMIT,
    ST_TAIL_EMIT,
    ST_ERR_EMIT
  } axts_state_t;

  typedef struct packed {
    logic        first_block;
    logic        last_block;
    logic [63:0] tweak_low;
    logic [63:0] tweak_high;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  valid_bytes;
  } axts_in_t;

  typedef struct packed {
    logic [63:0] out_low;
    logic [63:0] out_high;
    logic [4:0]  out_bytes;
    logic        out_last;
    logic        sector_error;
  } axts_out_t;

  typedef struct packed {
    logic start;
    logic dec;
    logic tweak_key;
  } axts_aes_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } axts_aes_sts_t;

  typedef struct packed {
    logic data;
    logic tweak;
  } axts_rekey_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Tweak times alpha in GF(2^128), little-endian byte order.
  function automatic logic [127:0] mul_alpha(input logic [127:0] t);
    logic [127:0] r;
    r = {t[126:0], 1'b0};
    if (t[127]) r[7:0] = r[7:0] ^ ALPHA_POLY;
    return r;
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic fin);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[8*(4*c+w) +: 8] = SBOX[s[8*(4*((c+w)&3)+w) +: 8]];
      end
    end
    m = t;
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[8*(4*c)   +: 8];
        a1 = t[8*(4*c+1) +: 8];
        a2 = t[8*(4*c+2) +: 8];
        a3 = t[8*(4*c+3) +: 8];
        m[8*(4*c)   +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        m[8*(4*c+1) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        m[8*(4*c+2) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        m[8*(4*c+3) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return m ^ k;
  endfunction

  function automatic logic [7:0] gm9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] gm11(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] gm13(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] gm14(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic fin);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[8*(4*((c+w)&3)+w) +: 8] = INV_SBOX[s[8*(4*c+w) +: 8]];
      end
    end
    t = t ^ k;
    m = t;
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[8*(4*c)   +: 8];
        a1 = t[8*(4*c+1) +: 8];
        a2 = t[8*(4*c+2) +: 8];
        a3 = t[8*(4*c+3) +: 8];
        m[8*(4*c)   +: 8] = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3);
        m[8*(4*c+1) +: 8] = gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3);
        m[8*(4*c+2) +: 8] = gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3);
        m[8*(4*c+3) +: 8] = gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3);
      end
    end
    return m;
  endfunction

  // One AES-128 key schedule step: previous round key to next.
  function automatic logic [127:0] key_step(input logic [127:0] w, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[w[103:96]], SBOX[w[127:120]], SBOX[w[119:112]], SBOX[w[111:104]] ^ rcon};
    w0 = w[31:0] ^ t;
    w1 = w[63:32] ^ w0;
    w2 = w[95:64] ^ w1;
    w3 = w[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

endpackage

`default_nettype wire

### hdl/axts_aes_core.sv
`timescale 1ns / 1ps
`default_nettype none

module axts_aes_core (
  input  logic                   clk,
  input  logic                   rst,
  input  axts_pkg::axts_aes_ctl_t ctl,
  input  logic [127:0]           block,
  input  logic [127:0]           data_key,
  input  logic [127:0]           tweak_key,
  input  axts_pkg::axts_rekey_t  rekey,
  output axts_pkg::axts_aes_sts_t sts,
  output logic [127:0]           result
);
  import axts_pkg::*;

  localparam logic [RK_IDX_W-1:0] RK_LAST = RK_IDX_W'(AES_ROUNDS);

  logic [127:0] rk_d [AES_ROUNDS+1];
  logic [127:0] rk_t [AES_ROUNDS+1];

  logic                pend_d, pend_t;
  logic                exp_on, exp_tw;
  logic [RK_IDX_W-1:0] exp_cnt;
  logic [127:0]        exp_word;
  logic [7:0]          rcon;

  logic                run, dec_r, tk_r, done;
  logic [RK_IDX_W-1:0] rnd;
  logic [127:0]        st;

  logic                exp_start;
  logic                wr_en, wr_tw;
  logic [RK_IDX_W-1:0] wr_addr;
  logic [127:0]        wr_data, exp_key, exp_next;
  logic [RK_IDX_W-1:0] rk_idx;
  logic                rk_sel, last_rnd;
  logic [127:0]        rk_q;

  // Expand the data key first when both are pending.
  assign exp_start = !exp_on && !run && (pend_d || pend_t);
  assign exp_key   = (exp_start ? !pend_d : exp_tw) ? tweak_key : data_key;
  assign exp_next  = key_step(exp_word, rcon);
  assign wr_en     = exp_start || exp_on;
  assign wr_tw     = exp_start ? !pend_d : exp_tw;
  assign wr_addr   = exp_start ? '0 : exp_cnt;
  assign wr_data   = exp_start ? exp_key : exp_next;

  assign rk_sel   = ctl.start ? ctl.tweak_key : tk_r;
  assign rk_idx   = ctl.start ? (ctl.dec ? RK_LAST : '0) : (dec_r ? RK_LAST - rnd : rnd);
  assign rk_q     = rk_sel ? rk_t[rk_idx] : rk_d[rk_idx];
  assign last_rnd = rnd == RK_LAST;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_tw) rk_t[wr_addr] <= wr_data;
      else       rk_d[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_d  <= 1'b1;
      pend_t  <= 1'b1;
      exp_on  <= 1'b0;
      exp_cnt <= '0;
      run     <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
    end else begin
      done <= run && last_rnd;
      if (exp_start) begin
        exp_on  <= 1'b1;
        exp_cnt <= RK_IDX_W'(1);
        if (pend_d) pend_d <= 1'b0;
        else        pend_t <= 1'b0;
      end else if (exp_on) begin
        exp_cnt <= exp_cnt + RK_IDX_W'(1);
        if (exp_cnt == RK_LAST) exp_on <= 1'b0;
      end
      if (rekey.data)  pend_d <= 1'b1;
      if (rekey.tweak) pend_t <= 1'b1;
      if (ctl.start) begin
        run <= 1'b1;
        rnd <= RK_IDX_W'(1);
      end else if (run) begin
        rnd <= rnd + RK_IDX_W'(1);
        if (last_rnd) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exp_start) begin
      exp_tw   <= !pend_d;
      exp_word <= exp_key;
      rcon     <= 8'h01;
    end else if (exp_on) begin
      exp_word <= exp_next;
      rcon     <= xt(rcon);
    end
    if (ctl.start) begin
      st    <= block ^ rk_q;
      dec_r <= ctl.dec;
      tk_r  <= ctl.tweak_key;
    end else if (run) begin
      st <= dec_r ? dec_round(st, rk_q, last_rnd) : enc_round(st, rk_q, last_rnd);
    end
  end

  assign sts.busy = run || exp_on || pend_d || pend_t;
  assign sts.done = done;
  assign result   = st;

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run))
    else $error("core done without a finishing round");
  a_no_exp_while_run: assert property (@(posedge clk) disable iff (rst)
    exp_on |-> !run)
    else $error("key expansion overlaps a block");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !sts.busy)
    else $error("core started while busy");

endmodule

`default_nettype wire

### hdl/aes128_xts_sector_crypt.sv
`timescale 1ns / 1ps
`default_nettype none

// AES-128 XTS sector encrypt/decrypt (IEEE 1619) with ciphertext stealing.
// One AES core with a single round unit does all the work: a pass loads the
// block, runs the ten rounds and hands back the result. An item takes one
// pass for the sector tweak on a first block, one pass for the block held
// back from the previous item, and one pass for the current block; a full
// block that is not last costs only its held-block pass. A result may also
// wait on out_stall. Each full block is held back one item so that a final
// partial block (0 to 15 bytes) can steal from it; that last item then emits
// two results, the full block first and the short tail with out_last set.
// Errors (sector under 16 bytes, partial block not last, block outside a
// sector) emit one result with sector_error set and close the sector.
// Round keys are expanded on chip, one round key per cycle, after each key
// register write and after reset; until that is done in_stall is high and
// cfg_ready is low. Write configuration only between items.
module aes128_xts_sector_crypt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  axts_pkg::axts_in_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output axts_pkg::axts_out_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [axts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data
);
  import axts_pkg::*;

  axts_state_t state, state_next;

  // configuration
  logic [127:0] data_key, tweak_key;
  logic         decrypt_mode;

  // sector state
  logic [127:0] tweak;
  logic [127:0] held;
  logic         held_valid;
  logic         in_sector;

  // item being worked on
  logic [127:0] cur, tw_in;
  logic [4:0]   vb;
  logic         steal_r, do_cur_r;

  logic          in_acc, cfg_acc, idle_ok, slot_free;
  logic [4:0]    vb_in;
  logic          full_in, hv_in, err_in;
  logic [127:0]  ta, taa, pass_tw, res, mix, tail;
  logic          held_pass;
  axts_aes_ctl_t core_ctl;
  axts_aes_sts_t core_sts;
  axts_rekey_t   rekey;
  logic [127:0]  core_block, core_result;
  logic          out_load;
  axts_out_t     out_next;

  axts_aes_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (core_ctl),
    .block     (core_block),
    .data_key  (data_key),
    .tweak_key (tweak_key),
    .rekey     (rekey),
    .sts       (core_sts),
    .result    (core_result)
  );

  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign slot_free = !out_valid || !out_stall;

  // Saturate oversized byte counts to a full block.
  assign vb_in   = (in_item.valid_bytes > BLK_BYTES) ? BLK_BYTES : in_item.valid_bytes;
  assign full_in = vb_in == BLK_BYTES;
  assign hv_in   = !in_item.first_block && held_valid;
  assign err_in  = (!in_item.first_block && !in_sector) ||
                   (!full_in && (!in_item.last_block || !hv_in));

  assign ta  = mul_alpha(tweak);
  assign taa = mul_alpha(ta);

  // Stealing swaps the two tweaks between passes depending on direction.
  assign held_pass = state == ST_HELD_GO || state == ST_HELD_RUN || state == ST_HELD_EMIT;
  always_comb begin
    if (held_pass) pass_tw = (steal_r && decrypt_mode) ? ta : tweak;
    else           pass_tw = (steal_r && !decrypt_mode) ? ta : tweak;
  end
  assign res = core_result ^ pass_tw;

  // Merge the short tail into the stolen block, and mask the emitted tail.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < vb) begin
        mix[8*j +: 8]  = cur[8*j +: 8];
        tail[8*j +: 8] = held[8*j +: 8];
      end else begin
        mix[8*j +: 8]  = held[8*j +: 8];
        tail[8*j +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    rekey.data  = 1'b0;
    rekey.tweak = 1'b0;
    if (cfg_acc) begin
      unique case (axts_reg_t'(cfg_index))
        REG_DATA_KEY_LOW, REG_DATA_KEY_HIGH:   rekey.data  = 1'b1;
        REG_TWEAK_KEY_LOW, REG_TWEAK_KEY_HIGH: rekey.tweak = 1'b1;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (err_in)                    state_next = ST_ERR_EMIT;
          else if (in_item.first_block)  state_next = ST_TWK_GO;
          else if (hv_in)                state_next = ST_HELD_GO;
          else if (in_item.last_block)   state_next = ST_CUR_GO;
        end
      end
      ST_TWK_GO:  state_next = ST_TWK_RUN;
      ST_TWK_RUN: if (core_sts.done) state_next = do_cur_r ? ST_CUR_GO : ST_IDLE;
      ST_HELD_GO: state_next = ST_HELD_RUN;
      ST_HELD_RUN: if (core_sts.done) state_next = steal_r ? ST_CUR_GO : ST_HELD_EMIT;
      ST_HELD_EMIT: if (slot_free) state_next = do_cur_r ? ST_CUR_GO : ST_IDLE;
      ST_CUR_GO:  state_next = ST_CUR_RUN;
      ST_CUR_RUN: if (core_sts.done) state_next = ST_CUR_EMIT;
      ST_CUR_EMIT: if (slot_free) state_next = steal_r ? ST_TAIL_EMIT : ST_IDLE;
      ST_TAIL_EMIT: if (slot_free) state_next = ST_IDLE;
      ST_ERR_EMIT:  if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle_ok   = state == ST_IDLE && !core_sts.busy;
    cfg_ready = idle_ok;
    in_stall  = !idle_ok || cfg_valid;
    core_ctl.start     = 1'b0;
    core_ctl.tweak_key = 1'b0;
    core_ctl.dec       = decrypt_mode;
    core_block = (steal_r ? mix : cur) ^ pass_tw;
    out_load   = 1'b0;
    out_next   = '0;
    unique case (state)
      ST_TWK_GO: begin
        core_ctl.start     = 1'b1;
        core_ctl.tweak_key = 1'b1;
        core_ctl.dec       = 1'b0;
        core_block         = tw_in;
      end
      ST_HELD_GO: begin
        core_ctl.start = 1'b1;
        core_block     = held ^ pass_tw;
      end
      ST_CUR_GO: core_ctl.start = 1'b1;
      ST_HELD_EMIT: begin
        out_load = slot_free;
        out_next = '{out_low: res[63:0], out_high: res[127:64], out_bytes: BLK_BYTES,
                     out_last: 1'b0, sector_error: 1'b0};
      end
      ST_CUR_EMIT: begin
        out_load = slot_free;
        out_next = '{out_low: res[63:0], out_high: res[127:64], out_bytes: BLK_BYTES,
                     out_last: !steal_r, sector_error: 1'b0};
      end
      ST_TAIL_EMIT: begin
        out_load = slot_free;
        out_next = '{out_low: tail[63:0], out_high: tail[127:64], out_bytes: vb,
                     out_last: 1'b1, sector_error: 1'b0};
      end
      ST_ERR_EMIT: begin
        out_load = slot_free;
        out_next = '{out_low: 64'd0, out_high: 64'd0, out_bytes: 5'd0,
                     out_last: 1'b1, sector_error: 1'b1};
      end
      default: ;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      data_key     <= '0;
      tweak_key    <= '0;
      decrypt_mode <= 1'b0;
      tweak        <= '0;
      held_valid   <= 1'b0;
      in_sector    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        unique case (axts_reg_t'(cfg_index))
          REG_DATA_KEY_LOW:   data_key[63:0]    <= cfg_data;
          REG_DATA_KEY_HIGH:  data_key[127:64]  <= cfg_data;
          REG_TWEAK_KEY_LOW:  tweak_key[63:0]   <= cfg_data;
          REG_TWEAK_KEY_HIGH: tweak_key[127:64] <= cfg_data;
          REG_DECRYPT_MODE:   decrypt_mode      <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (err_in) begin
          in_sector  <= 1'b0;
          held_valid <= 1'b0;
        end else if (in_item.first_block) begin
          in_sector  <= 1'b1;
          held_valid <= 1'b0;
        end else if (!hv_in && !in_item.last_block) begin
          held_valid <= 1'b1;
        end
      end
      if (state == ST_TWK_RUN && core_sts.done) begin
        tweak <= core_result;
        if (!do_cur_r) held_valid <= 1'b1;
      end
      if (state == ST_HELD_EMIT && slot_free) begin
        tweak      <= ta;
        held_valid <= !do_cur_r;
      end
      if (state == ST_CUR_EMIT && slot_free && !steal_r) begin
        tweak     <= ta;
        in_sector <= 1'b0;
      end
      if (state == ST_TAIL_EMIT && slot_free) begin
        tweak      <= taa;
        in_sector  <= 1'b0;
        held_valid <= 1'b0;
      end
      if (out_load)      out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur      <= {in_item.data_high, in_item.data_low};
      tw_in    <= {in_item.tweak_high, in_item.tweak_low};
      vb       <= vb_in;
      steal_r  <= !full_in;
      do_cur_r <= in_item.last_block;
      // hold a full non-last block right away when nothing is pending
      if (!in_item.first_block && !hv_in && !in_item.last_block)
        held <= {in_item.data_high, in_item.data_low};
    end
    if (state == ST_TWK_RUN && core_sts.done && !do_cur_r) held <= cur;
    if (state == ST_HELD_RUN && core_sts.done && steal_r) held <= res;
    if (state == ST_HELD_EMIT && slot_free && !do_cur_r) held <= cur;
    if (out_load) out_item <= out_next;
  end

  a_sector_holds: assert property (@(posedge clk) disable iff (rst)
    !in_sector |-> !held_valid)
    else $error("block held outside an open sector");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("waiting result overwritten");
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    core_sts.done |-> (state == ST_TWK_RUN || state == ST_HELD_RUN || state == ST_CUR_RUN))
    else $error("core finished outside a run state");

endmodule

`default_nettype wire
